// ===== hdl/notification_ring_queue_assert.svh =====
// ----------------------------------------------------------------------------
// notification_ring_queue assertion macros
// Shared concurrent assertion forms, clocked on clk and held off during rst.
// ----------------------------------------------------------------------------
`ifndef NOTIFICATION_RING_QUEUE_ASSERT_SVH
`define NOTIFICATION_RING_QUEUE_ASSERT_SVH

// same-cycle implication
`define NRQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define NRQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/nrq_pkg.sv =====
// ----------------------------------------------------------------------------
// nrq_pkg
// Operation, status and link codes and the sequencer state type.
// ----------------------------------------------------------------------------
package nrq_pkg;

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_SEND  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_FLUSH = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    STS_OK      = 3'd0,
    STS_EMPTY   = 3'd1,
    STS_FULL    = 3'd2,
    STS_BUSY    = 3'd3,
    STS_BAD_LEN = 3'd4,
    STS_FAILED  = 3'd5
  } status_t;

  localparam logic [1:0] LINK_OK    = 2'd0;
  localparam logic [1:0] LINK_BUSY  = 2'd1;
  localparam logic [1:0] LINK_FAIL  = 2'd2;
  localparam logic [1:0] LINK_SPARE = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_READ   = 4'b0010,
    S_UPD    = 4'b0100,
    S_STREAM = 4'b1000
  } state_t;

endpackage

// ===== hdl/notification_ring_queue.sv =====
// ----------------------------------------------------------------------------
// notification_ring_queue
// Ring of notification entries with link send statistics.
// ----------------------------------------------------------------------------
// One request is handled at a time. Push, clear, flush and a send to an empty
// ring each give one result. A send to a non-empty ring reads the oldest
// entry from the entry memory, forms the latency terms and updates the
// statistics; busy or failure then gives one result, while success streams
// the stored bytes from the payload memory one per cycle while the receiver
// does not stall. The single read port of each memory sets this order of
// steps. The stores power up undefined and need no clearing pass;
// statistics and pointers reset at once.
`include "notification_ring_queue_assert.svh"

module notification_ring_queue import nrq_pkg::*; #(
  parameter int RING_DEPTH  = 16,
  parameter int MAX_PAYLOAD = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  logic [1:0]  operation,
  input  logic [7:0]  data_byte,
  input  logic        byte_last,
  input  logic [15:0] char_handle,
  input  logic [31:0] tick_now,
  input  logic [1:0]  link_status,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output logic [2:0]  status,
  output logic [7:0]  out_byte,
  output logic        out_last,
  output logic [15:0] out_handle,
  output logic [3:0]  fill_level,
  output logic [3:0]  peak_level,
  output logic [31:0] enqueued_total,
  output logic [31:0] sent_total,
  output logic [31:0] dropped_total,
  output logic [31:0] link_error_total,
  output logic [31:0] latency_average,
  output logic [31:0] latency_peak
);

  localparam int PW  = $clog2(RING_DEPTH);
  localparam int PSW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam int GW  = $clog2(MAX_PAYLOAD + 2);
  localparam int LW  = $clog2(MAX_PAYLOAD + 1);
  localparam int EW  = 16 + LW + 32;
  localparam int PD  = RING_DEPTH * (2 ** PSW);
  localparam logic [PW-1:0] LAST_SLOT = PW'(RING_DEPTH - 1);
  localparam logic [PW-1:0] DEPTH_P   = PW'(RING_DEPTH);
  localparam logic [GW-1:0] MAX_G     = GW'(MAX_PAYLOAD);
  localparam logic [LW-1:0] MAX_L     = LW'(MAX_PAYLOAD);

  function automatic logic [PW-1:0] advance(input logic [PW-1:0] p);
    return (p == LAST_SLOT) ? '0 : p + 1'b1;
  endfunction

  state_t        state;
  logic [PW-1:0] head;
  logic [PW-1:0] tail;
  logic [GW-1:0] gathered;
  logic [31:0]   enq_cnt;
  logic [31:0]   sent_cnt;
  logic [31:0]   drop_cnt;
  logic [31:0]   lerr_cnt;
  logic [PW-1:0] peak_fill;
  logic [31:0]   avg_lat;
  logic [31:0]   peak_lat;
  logic [31:0]   tick_q;
  logic [1:0]    link_q;
  logic [31:0]   lat_q;
  logic [34:0]   avg7_q;
  logic [15:0]   snd_handle;
  logic [LW-1:0] snd_len;
  logic [PW-1:0] slot_q;
  logic [LW-1:0] fetch;

  logic          out_free;
  logic          req_acc;
  op_t           op;
  logic [PW-1:0] fill;
  logic [PW-1:0] head_adv;
  logic [GW-1:0] g_inc;
  status_t       push_sts;
  logic          push_ok;
  logic          emit;
  logic          emit_last;
  logic [34:0]   avg_sum;
  logic [31:0]   avg_next;
  logic [LW-1:0] len_fix;
  logic [LW-1:0] fetch_sel;

  logic                 p_we;
  logic [PW+PSW-1:0]    p_waddr;
  logic [PW+PSW-1:0]    p_raddr;
  logic [PSW-1:0]       rd_idx;
  logic [PW-1:0]        rd_slot;
  logic [7:0]           p_rdata;
  logic                 e_we;
  logic [EW-1:0]        e_wdata;
  logic [EW-1:0]        e_rdata;
  logic [15:0]          e_handle;
  logic [LW-1:0]        e_len;
  logic [31:0]          e_arr;

  assign out_free  = !rsp_valid || !rsp_stall;
  assign req_stall = !((state == S_IDLE) && out_free);
  assign req_acc   = req_valid && !req_stall;
  assign op        = op_t'(operation);

  assign fill     = (head >= tail) ? head - tail : DEPTH_P - tail + head;
  assign head_adv = advance(head);
  assign g_inc    = (gathered <= MAX_G) ? gathered + 1'b1 : gathered;

  always_comb begin
    push_ok  = 1'b0;
    push_sts = STS_OK;
    if (byte_last) begin
      if (g_inc > MAX_G) begin
        push_sts = STS_BAD_LEN;
      end else if (head_adv == tail) begin
        push_sts = STS_FULL;
      end else begin
        push_ok = 1'b1;
      end
    end
  end

  // payload memory: slot-major, power-of-two stride per slot
  assign p_we    = req_acc && (op == OP_PUSH) && (gathered < MAX_G);
  assign p_waddr = {head, gathered[PSW-1:0]};

  assign emit      = (state == S_STREAM) && out_free;
  assign emit_last = (fetch == snd_len - 1'b1);
  assign fetch_sel = emit ? fetch + 1'b1 : fetch;

  always_comb begin
    if (state == S_STREAM) begin
      rd_slot = slot_q;
      rd_idx  = fetch_sel[PSW-1:0];
    end else begin
      rd_slot = tail;
      rd_idx  = '0;
    end
  end
  assign p_raddr = {rd_slot, rd_idx};

  nrq_ram #(.WIDTH(8), .DEPTH(PD)) u_payload (
    .clk   (clk),
    .we    (p_we),
    .waddr (p_waddr),
    .wdata (data_byte),
    .raddr (p_raddr),
    .rdata (p_rdata)
  );

  // entry memory: handle, length, arrival tick
  assign e_we    = req_acc && (op == OP_PUSH) && push_ok;
  assign e_wdata = {char_handle, LW'(g_inc), tick_now};

  nrq_ram #(.WIDTH(EW), .DEPTH(RING_DEPTH)) u_entry (
    .clk   (clk),
    .we    (e_we),
    .waddr (head),
    .wdata (e_wdata),
    .raddr (tail),
    .rdata (e_rdata)
  );

  assign e_handle = e_rdata[EW-1 -: 16];
  assign e_len    = e_rdata[32 +: LW];
  assign e_arr    = e_rdata[31:0];

  assign avg_sum  = avg7_q + {3'b000, lat_q};
  assign avg_next = (avg_lat == '0) ? lat_q : avg_sum[34:3];
  assign len_fix  = ((e_len == '0) || (e_len > MAX_L)) ? LW'(1) : e_len;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      tail      <= '0;
      gathered  <= '0;
      enq_cnt   <= '0;
      sent_cnt  <= '0;
      drop_cnt  <= '0;
      lerr_cnt  <= '0;
      peak_fill <= '0;
      avg_lat   <= '0;
      peak_lat  <= '0;
      rsp_valid <= 1'b0;
      fetch     <= '0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_acc) begin
            rsp_valid  <= 1'b1;
            status     <= STS_OK;
            out_byte   <= '0;
            out_last   <= 1'b1;
            out_handle <= '0;
            tick_q     <= tick_now;
            link_q     <= link_status;
            case (op)
              OP_PUSH: begin
                status <= push_sts;
                if (byte_last) begin
                  gathered <= '0;
                  if (push_sts == STS_FULL) begin
                    drop_cnt <= drop_cnt + 1'b1;
                  end
                  if (push_ok) begin
                    head    <= head_adv;
                    enq_cnt <= enq_cnt + 1'b1;
                    if (PW'(fill + 1'b1) > peak_fill) begin
                      peak_fill <= PW'(fill + 1'b1);
                    end
                  end
                end else begin
                  gathered <= g_inc;
                end
              end
              OP_SEND: begin
                if (head == tail) begin
                  status <= STS_EMPTY;
                end else begin
                  rsp_valid <= 1'b0;
                  state     <= S_READ;
                end
              end
              OP_CLEAR: begin
                enq_cnt   <= '0;
                sent_cnt  <= '0;
                drop_cnt  <= '0;
                lerr_cnt  <= '0;
                peak_fill <= '0;
                avg_lat   <= '0;
                peak_lat  <= '0;
              end
              default: begin
                head      <= '0;
                tail      <= '0;
                gathered  <= '0;
                enq_cnt   <= '0;
                sent_cnt  <= '0;
                drop_cnt  <= '0;
                lerr_cnt  <= '0;
                peak_fill <= '0;
                avg_lat   <= '0;
                peak_lat  <= '0;
              end
            endcase
          end
        end
        S_READ: begin
          lat_q  <= tick_q - e_arr;
          avg7_q <= {avg_lat, 3'b000} - {3'b000, avg_lat};
          state  <= S_UPD;
        end
        S_UPD: begin
          avg_lat <= avg_next;
          if (lat_q > peak_lat) begin
            peak_lat <= lat_q;
          end
          if (link_q == LINK_OK) begin
            snd_handle <= e_handle;
            snd_len    <= len_fix;
            slot_q     <= tail;
            fetch      <= '0;
            tail       <= advance(tail);
            sent_cnt   <= sent_cnt + 1'b1;
            state      <= S_STREAM;
          end else begin
            lerr_cnt   <= lerr_cnt + 1'b1;
            rsp_valid  <= 1'b1;
            out_byte   <= '0;
            out_last   <= 1'b1;
            out_handle <= '0;
            state      <= S_IDLE;
            if (link_q == LINK_BUSY) begin
              status <= STS_BUSY;
            end else begin
              status <= STS_FAILED;
              tail   <= advance(tail);
            end
          end
        end
        S_STREAM: begin
          if (emit) begin
            rsp_valid  <= 1'b1;
            status     <= STS_OK;
            out_byte   <= p_rdata;
            out_last   <= emit_last;
            out_handle <= snd_handle;
            fetch      <= fetch_sel;
            if (emit_last) begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign fill_level       = 4'(fill);
  assign peak_level       = 4'(peak_fill);
  assign enqueued_total   = enq_cnt;
  assign sent_total       = sent_cnt;
  assign dropped_total    = drop_cnt;
  assign link_error_total = lerr_cnt;
  assign latency_average  = avg_lat;
  assign latency_peak     = peak_lat;

  `NRQ_ASSERT_NEXT(a_req_progress, req_acc, rsp_valid || (state == S_READ), "request lost")
  `NRQ_ASSERT_NOW(a_upd_out_free, state == S_UPD, !rsp_valid, "result register busy in update")
  `NRQ_ASSERT_NOW(a_stream_bound, state == S_STREAM, fetch < snd_len, "stream index past length")

endmodule

// ===== hdl/nrq_ram.sv =====
// ----------------------------------------------------------------------------
// nrq_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module nrq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// notification_ring_queue testbench
// Drives push, send, clear and flush requests through the valid/stall
// request channel with random gaps and receiver stalls. A local ring and
// statistics predictor builds the expected result stream, and every
// accepted result is compared field by field, in order.
// ----------------------------------------------------------------------------
module testbench;
  import nrq_pkg::*;

  localparam int RING_DEPTH  = 16;
  localparam int MAX_PAYLOAD = 32;

  typedef struct {
    op_t         op;
    logic [7:0]  data_byte;
    logic        byte_last;
    logic [15:0] char_handle;
    logic [31:0] tick_now;
    logic [1:0]  link_status;
  } request_t;

  typedef struct {
    status_t     status;
    logic [7:0]  out_byte;
    logic        out_last;
    logic [15:0] out_handle;
    logic [3:0]  fill_level;
    logic [3:0]  peak_level;
    logic [31:0] enqueued_total;
    logic [31:0] sent_total;
    logic [31:0] dropped_total;
    logic [31:0] link_error_total;
    logic [31:0] latency_average;
    logic [31:0] latency_peak;
  } notice_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_stall;
  logic [1:0]  operation = OP_PUSH;
  logic [7:0]  data_byte = 8'd0;
  logic        byte_last = 1'b0;
  logic [15:0] char_handle = 16'd0;
  logic [31:0] tick_now = 32'd0;
  logic [1:0]  link_status = LINK_OK;
  logic        rsp_valid;
  logic        rsp_stall = 1'b0;
  logic [2:0]  status;
  logic [7:0]  out_byte;
  logic        out_last;
  logic [15:0] out_handle;
  logic [3:0]  fill_level;
  logic [3:0]  peak_level;
  logic [31:0] enqueued_total;
  logic [31:0] sent_total;
  logic [31:0] dropped_total;
  logic [31:0] link_error_total;
  logic [31:0] latency_average;
  logic [31:0] latency_peak;

  notification_ring_queue #(
    .RING_DEPTH  (RING_DEPTH),
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) dut (
    .clk              (clk),
    .rst              (rst),
    .req_valid        (req_valid),
    .req_stall        (req_stall),
    .operation        (operation),
    .data_byte        (data_byte),
    .byte_last        (byte_last),
    .char_handle      (char_handle),
    .tick_now         (tick_now),
    .link_status      (link_status),
    .rsp_valid        (rsp_valid),
    .rsp_stall        (rsp_stall),
    .status           (status),
    .out_byte         (out_byte),
    .out_last         (out_last),
    .out_handle       (out_handle),
    .fill_level       (fill_level),
    .peak_level       (peak_level),
    .enqueued_total   (enqueued_total),
    .sent_total       (sent_total),
    .dropped_total    (dropped_total),
    .link_error_total (link_error_total),
    .latency_average  (latency_average),
    .latency_peak     (latency_peak)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #20_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // predicted ring contents and statistics
  logic [7:0]  ring_payload [RING_DEPTH * MAX_PAYLOAD];
  logic [15:0] ring_handle [RING_DEPTH];
  logic [5:0]  ring_length [RING_DEPTH];
  logic [31:0] ring_arrival [RING_DEPTH];
  logic [3:0]  ring_head = 4'd0;
  logic [3:0]  ring_tail = 4'd0;
  int unsigned ring_gathered = 0;
  logic [31:0] stat_enqueued = 32'd0;
  logic [31:0] stat_sent = 32'd0;
  logic [31:0] stat_dropped = 32'd0;
  logic [31:0] stat_link_errors = 32'd0;
  logic [3:0]  stat_peak_fill = 4'd0;
  logic [31:0] stat_avg_latency = 32'd0;
  logic [31:0] stat_peak_latency = 32'd0;

  notice_t     pending_results [$];
  int          error_count = 0;
  int unsigned request_count = 0;
  logic [31:0] tick_clock = 32'd0;
  bit          tick_jumps = 1'b0;
  bit          sender_idles = 1'b1;
  bit          receiver_idles = 1'b1;
  int          rsp_hold_cycles = 0;

  function automatic notice_t ring_notice(status_t st, logic [7:0] b, logic last,
                                          logic [15:0] h);
    notice_t n;
    n.status           = st;
    n.out_byte         = b;
    n.out_last         = last;
    n.out_handle       = h;
    n.fill_level       = ring_head - ring_tail;
    n.peak_level       = stat_peak_fill;
    n.enqueued_total   = stat_enqueued;
    n.sent_total       = stat_sent;
    n.dropped_total    = stat_dropped;
    n.link_error_total = stat_link_errors;
    n.latency_average  = stat_avg_latency;
    n.latency_peak     = stat_peak_latency;
    return n;
  endfunction

  function automatic void clear_ring_stats();
    stat_enqueued     = 32'd0;
    stat_sent         = 32'd0;
    stat_dropped      = 32'd0;
    stat_link_errors  = 32'd0;
    stat_peak_fill    = 4'd0;
    stat_avg_latency  = 32'd0;
    stat_peak_latency = 32'd0;
  endfunction

  function automatic void predict_ring_results(request_t r);
    status_t     st;
    int unsigned len;
    logic [3:0]  slot;
    logic [3:0]  fill;
    logic [31:0] lat;
    logic [63:0] wide;
    st = STS_OK;
    case (r.op)
      OP_PUSH: begin
        if (ring_gathered < MAX_PAYLOAD)
          ring_payload[ring_head * MAX_PAYLOAD + ring_gathered] = r.data_byte;
        if (ring_gathered <= MAX_PAYLOAD)
          ring_gathered++;
        if (r.byte_last) begin
          len = ring_gathered;
          ring_gathered = 0;
          if (len > MAX_PAYLOAD) begin
            st = STS_BAD_LEN;
          end else if (ring_head + 4'd1 == ring_tail) begin
            stat_dropped++;
            st = STS_FULL;
          end else begin
            ring_handle[ring_head]  = r.char_handle;
            ring_length[ring_head]  = 6'(len);
            ring_arrival[ring_head] = r.tick_now;
            ring_head++;
            stat_enqueued++;
            fill = ring_head - ring_tail;
            if (fill > stat_peak_fill)
              stat_peak_fill = fill;
          end
        end
      end
      OP_SEND: begin
        if (ring_head == ring_tail) begin
          st = STS_EMPTY;
        end else begin
          slot = ring_tail;
          lat = r.tick_now - ring_arrival[slot];
          if (lat > stat_peak_latency)
            stat_peak_latency = lat;
          if (stat_avg_latency == 32'd0) begin
            stat_avg_latency = lat;
          end else begin
            wide = {32'd0, stat_avg_latency} * 64'd7 + {32'd0, lat};
            stat_avg_latency = wide[34:3];
          end
          if (r.link_status == LINK_OK) begin
            ring_tail++;
            stat_sent++;
            for (int k = 0; k < ring_length[slot]; k++)
              pending_results.push_back(ring_notice(STS_OK,
                ring_payload[slot * MAX_PAYLOAD + k], k + 1 == ring_length[slot],
                ring_handle[slot]));
            return;
          end else if (r.link_status == LINK_BUSY) begin
            stat_link_errors++;
            st = STS_BUSY;
          end else begin
            stat_link_errors++;
            ring_tail++;
            st = STS_FAILED;
          end
        end
      end
      OP_CLEAR: begin
        clear_ring_stats();
      end
      default: begin
        ring_head = 4'd0;
        ring_tail = 4'd0;
        ring_gathered = 0;
        clear_ring_stats();
      end
    endcase
    pending_results.push_back(ring_notice(st, 8'd0, 1'b1, 16'd0));
  endfunction

  function automatic logic [31:0] next_tick();
    if (tick_jumps && $urandom_range(0, 19) == 0)
      tick_clock = $urandom;
    else
      tick_clock += $urandom_range(0, 40);
    return tick_clock;
  endfunction

  function automatic void check_field(string name, logic [31:0] expected,
                                      logic [31:0] actual);
    if (actual !== expected) begin
      $error("%s mismatch: expected %0h, got %0h", name, expected, actual);
      error_count++;
    end
  endfunction

  // result checker
  always @(posedge clk) begin : check_results
    notice_t exp;
    if (!rst && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: status %0d byte %0h", status, out_byte);
        error_count++;
      end else begin
        exp = pending_results.pop_front();
        check_field("status", 32'(exp.status), 32'(status));
        check_field("out_byte", 32'(exp.out_byte), 32'(out_byte));
        check_field("out_last", 32'(exp.out_last), 32'(out_last));
        check_field("out_handle", 32'(exp.out_handle), 32'(out_handle));
        check_field("fill_level", 32'(exp.fill_level), 32'(fill_level));
        check_field("peak_level", 32'(exp.peak_level), 32'(peak_level));
        check_field("enqueued_total", exp.enqueued_total, enqueued_total);
        check_field("sent_total", exp.sent_total, sent_total);
        check_field("dropped_total", exp.dropped_total, dropped_total);
        check_field("link_error_total", exp.link_error_total, link_error_total);
        check_field("latency_average", exp.latency_average, latency_average);
        check_field("latency_peak", exp.latency_peak, latency_peak);
      end
    end
  end

  // receiver stalls: long hold on request, else random bursts
  initial begin
    forever begin
      @(posedge clk);
      if (rsp_hold_cycles != 0) begin
        rsp_stall <= 1'b1;
        repeat (rsp_hold_cycles) @(posedge clk);
        rsp_hold_cycles = 0;
        rsp_stall <= 1'b0;
      end else if (receiver_idles && $urandom_range(0, 5) == 0) begin
        rsp_stall <= 1'b1;
        repeat ($urandom_range(1, 13)) @(posedge clk);
        rsp_stall <= 1'b0;
      end
    end
  end

  task automatic issue_request(op_t op, logic [7:0] b, logic last, logic [15:0] h,
                               logic [1:0] link);
    request_t r;
    if (sender_idles && $urandom_range(0, 4) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    r.op          = op;
    r.data_byte   = b;
    r.byte_last   = last;
    r.char_handle = h;
    r.tick_now    = next_tick();
    r.link_status = link;
    req_valid   <= 1'b1;
    operation   <= r.op;
    data_byte   <= r.data_byte;
    byte_last   <= r.byte_last;
    char_handle <= r.char_handle;
    tick_now    <= r.tick_now;
    link_status <= r.link_status;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    predict_ring_results(r);
    request_count++;
  endtask

  task automatic push_entry(int unsigned len, logic [15:0] handle);
    for (int unsigned i = 0; i < len; i++)
      issue_request(OP_PUSH, 8'($urandom), i + 1 == len,
                    (i + 1 == len) ? handle : 16'($urandom), 2'($urandom));
  endtask

  task automatic send_head(logic [1:0] link);
    issue_request(OP_SEND, 8'($urandom), 1'($urandom), 16'($urandom), link);
  endtask

  task automatic wait_for_drain();
    req_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic int unsigned random_length();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 70)
      return $urandom_range(1, 6);
    else if (pick < 93)
      return $urandom_range(7, MAX_PAYLOAD);
    return $urandom_range(MAX_PAYLOAD + 1, MAX_PAYLOAD + 4);
  endfunction

  function automatic logic [1:0] random_link();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 70)
      return LINK_OK;
    else if (pick < 85)
      return LINK_BUSY;
    else if (pick < 93)
      return LINK_FAIL;
    return LINK_SPARE;
  endfunction

  task automatic random_action();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 55)
      push_entry(random_length(), 16'($urandom));
    else if (pick < 88)
      send_head(random_link());
    else if (pick < 93)
      issue_request(OP_PUSH, 8'($urandom), 1'($urandom), 16'($urandom),
                    2'($urandom));  // stray byte
    else if (pick < 95)
      issue_request(OP_SEND, 8'($urandom), 1'($urandom), 16'($urandom), 2'($urandom));
    else if (pick < 98)
      issue_request(OP_CLEAR, 8'($urandom), 1'($urandom), 16'($urandom), 2'($urandom));
    else
      issue_request(OP_FLUSH, 8'($urandom), 1'($urandom), 16'($urandom), 2'($urandom));
  endtask

  task automatic test_random_traffic(int unsigned target);
    int unsigned start;
    start = request_count;
    while (request_count - start < target)
      random_action();
  endtask

  task automatic test_empty_ring();
    send_head(LINK_OK);
    issue_request(OP_CLEAR, 8'hFF, 1'b1, 16'hFFFF, LINK_SPARE);
    issue_request(OP_FLUSH, 8'h00, 1'b0, 16'h0000, LINK_OK);
  endtask

  task automatic test_payload_extremes();
    push_entry(1, 16'hFFFF);
    push_entry(MAX_PAYLOAD, 16'h0000);
    send_head(LINK_OK);
    send_head(LINK_OK);
    send_head(LINK_OK);
  endtask

  task automatic test_link_outcomes();
    push_entry(3, 16'h1234);
    push_entry(2, 16'hABCD);
    push_entry(1, 16'h5A5A);
    send_head(LINK_BUSY);
    send_head(LINK_FAIL);
    send_head(LINK_SPARE);
    send_head(LINK_OK);
  endtask

  task automatic test_bad_length();
    push_entry(MAX_PAYLOAD + 1, 16'h0F0F);
    push_entry(MAX_PAYLOAD + 4, 16'hF0F0);
    send_head(LINK_OK);
  endtask

  task automatic test_full_ring();
    for (int i = 0; i < RING_DEPTH - 1; i++)
      push_entry(1, 16'($urandom));
    push_entry(2, 16'hDEAD);
    issue_request(OP_CLEAR, 8'($urandom), 1'($urandom), 16'($urandom), 2'($urandom));
    for (int i = 0; i < RING_DEPTH; i++)
      send_head(LINK_OK);
  endtask

  task automatic test_flush_partial();
    push_entry(2, 16'h0101);
    for (int i = 0; i < 3; i++)
      issue_request(OP_PUSH, 8'($urandom), 1'b0, 16'($urandom), 2'($urandom));
    issue_request(OP_FLUSH, 8'($urandom), 1'($urandom), 16'($urandom), 2'($urandom));
    push_entry(1, 16'h0202);
    send_head(LINK_OK);
  endtask

  task automatic test_latency_wrap();
    tick_clock = 32'hFFFF_FFF0;
    push_entry(1, 16'h7777);
    tick_clock = 32'h0000_0010;
    send_head(LINK_OK);
    for (int i = 0; i < 2; i++) begin
      tick_clock = 32'h0000_0000;
      push_entry(1, 16'h8888);
      tick_clock = 32'hF000_0000;
      send_head(LINK_BUSY);
      send_head(LINK_OK);
    end
  endtask

  // receiver holds off while requests keep coming, so the block backs up
  task automatic test_backpressure();
    rsp_hold_cycles = 400;
    for (int i = 0; i < 16; i++)
      push_entry(2, 16'($urandom));
    for (int i = 0; i < 16; i++)
      send_head(LINK_OK);
    wait_for_drain();
  endtask

  task automatic test_drain_pause();
    for (int i = 0; i < 3; i++) begin
      test_random_traffic(6);
      wait_for_drain();
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_empty_ring();
    test_payload_extremes();
    test_link_outcomes();
    test_bad_length();
    test_full_ring();
    test_flush_partial();
    test_latency_wrap();
    tick_jumps = 1'b1;
    test_random_traffic(30);
    test_backpressure();
    test_drain_pause();
    sender_idles = 1'b0;
    receiver_idles = 1'b0;
    test_random_traffic(15);
    wait_for_drain();
    repeat (16) @(posedge clk);
    if (error_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/nrq_pkg.sv
hdl/nrq_ram.sv
hdl/notification_ring_queue.sv
dv/testbench.sv
